[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared types, widths and status codes for the queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int TIME_W   = 32;
    localparam int CART_W   = 16;
    localparam int ITEMS_W  = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef struct packed {
        logic [TIME_W-1:0]  ready_time;
        logic [CART_W-1:0]  cart_id;
        logic [ITEMS_W-1:0] item_total;
    } t_entry;

    // Operation applied to every cell in the same cycle.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY_REMOVE = 2'd1,
        ST_FULL_INSERT  = 2'd2
    } t_status;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

endpackage

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Stable sorted priority queue cell
// Holds one entry. On an insert it keeps its entry, takes the new entry or
// takes its left neighbour's entry; on a remove it takes its right
// neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_at_fill,
    input  logic                i_left_gt,
    input  spq_pkg::t_entry     i_left_entry,
    input  spq_pkg::t_entry     i_right_entry,
    input  spq_pkg::t_entry     i_new_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_gt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Strictly greater, so a new entry lands after all entries with an equal key.
    assign o_gt    = i_occupied && (r_entry.ready_time > i_new_entry.ready_time);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (o_gt || i_at_fill) begin
                n_entry = i_left_gt ? i_left_entry : i_new_entry;
            end
        end else if (i_ctrl.remove) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hw/rtl/stable_sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// Stable sorted priority queue core
// Bounded queue ordered by ready time, held in a row of shifting cells.
// ----------------------------------------------------------------------------
// A transaction is taken at every rising edge with start high; busy is never
// raised, so one transaction per clock is sustained. Its result appears on
// the o_ ports, marked by o_done, for exactly one cycle starting in the cycle
// after acceptance, and the receiver cannot stall it. Each cell compares the
// new key against its own entry in parallel, so the insert or remove
// completes at the accepting edge whatever the occupancy. Inserting into a
// full queue and removing from an empty one leave the contents unchanged and
// are flagged in o_status; ties leave in arrival order.
module stable_sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [spq_pkg::TIME_W-1:0]    i_ready_time,
    input  logic [spq_pkg::CART_W-1:0]    i_cart_id,
    input  logic [spq_pkg::ITEMS_W-1:0]   i_item_total,
    output logic                          o_done,
    output logic [spq_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_is_empty,
    output logic [spq_pkg::TIME_W-1:0]    o_head_time,
    output logic [spq_pkg::CART_W-1:0]    o_head_cart,
    output logic [spq_pkg::ITEMS_W-1:0]   o_head_items,
    output logic [spq_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic                   r_done;
    spq_pkg::t_status       r_status;
    spq_pkg::t_status       n_status;
    spq_pkg::t_cell_ctrl    cell_ctrl;
    spq_pkg::t_entry        new_entry;
    spq_pkg::t_entry        cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_gt;
    logic                   is_full;
    logic                   is_empty;

    assign busy     = 1'b0;
    assign is_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign is_empty = (r_fill == '0);

    assign new_entry.ready_time = i_ready_time;
    assign new_entry.cart_id    = i_cart_id;
    assign new_entry.item_total = i_item_total;

    always_comb begin
        cell_ctrl = '0;
        n_fill    = r_fill;
        n_status  = spq_pkg::ST_OK;
        if (start) begin
            if (spq_pkg::t_action'(i_action) == spq_pkg::ACT_INSERT) begin
                if (is_full) begin
                    n_status = spq_pkg::ST_FULL_INSERT;
                end else begin
                    cell_ctrl.insert = 1'b1;
                    n_fill           = r_fill + FILL_W'(1);
                end
            end else begin
                if (is_empty) begin
                    n_status = spq_pkg::ST_EMPTY_REMOVE;
                end else begin
                    cell_ctrl.remove = 1'b1;
                    n_fill           = r_fill - FILL_W'(1);
                end
            end
        end
    end

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic            left_gt;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        if (gi == 0) begin : g_first
            assign left_gt    = 1'b0;
            assign left_entry = new_entry;
        end else begin : g_inner
            assign left_gt    = cell_gt[gi-1];
            assign left_entry = cell_entry[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_occupied    (FILL_W'(gi) < r_fill),
            .i_at_fill     (FILL_W'(gi) == r_fill),
            .i_left_gt     (left_gt),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .i_new_entry   (new_entry),
            .o_entry       (cell_entry[gi]),
            .o_gt          (cell_gt[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_done   <= 1'b0;
            r_status <= spq_pkg::ST_OK;
        end else begin
            r_fill   <= n_fill;
            r_done   <= start;
            r_status <= n_status;
        end
    end

    // The result reflects the cells after the transaction has been applied.
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_is_empty   = is_empty;
    assign o_head_time  = is_empty ? '0 : cell_entry[0].ready_time;
    assign o_head_cart  = is_empty ? '0 : cell_entry[0].cart_id;
    assign o_head_items = is_empty ? '0 : cell_entry[0].item_total;
    assign o_occupancy  = spq_pkg::OCC_W'(r_fill);

endmodule
